FILE: hdl/grhh_pkg.sv
// Shared constants, payload structs and tables for the horizontal grid ray hit unit.
// No dependencies; used by grhh_cot and grid_ray_horizontal_hit_unit.

package grhh_pkg;

    // Map geometry
    localparam int MAP_WIDTH  = 8;
    localparam int MAP_HEIGHT = 8;
    localparam int TILE_SHIFT = 6;
    localparam int DEPTH      = (MAP_WIDTH >= MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int MAP_BITS   = 64;
    localparam int MAP_IDX_W  = $clog2(MAP_BITS);
    localparam int COL_W      = $clog2(MAP_WIDTH);
    localparam int ROW_W      = $clog2(MAP_HEIGHT);

    // Fixed-point layout
    localparam int FRAC_W     = 8;                    // Q.8 pixels
    localparam int CELL_SHIFT = TILE_SHIFT + FRAC_W;  // pixel Q.8 -> tile index
    localparam int COT_FRAC   = 16;                   // cotangent is Q.16
    localparam int XO_SHIFT   = COT_FRAC - CELL_SHIFT;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int POS_W   = 17;
    localparam int OUT_W   = 24;
    localparam int STEP_W  = 4;
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(32768);
    localparam int U_W        = ANGLE_W - 1;
    localparam logic [U_W-1:0] QUARTER = U_W'(16384);

    // CORDIC and divider
    localparam int CORDIC_STAGES = 17;
    localparam int XY_W   = 32;                // x, y datapath, signed
    localparam int Z_W    = 25;                // residual angle, signed
    localparam int XMAG_W = 30;                // |x| < 2^29 after rotation
    localparam int DVS_W  = XY_W - 1;          // positive divisor
    localparam int QUO_W  = XMAG_W + COT_FRAC; // quotient bits, one per divide step
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int ATAN_IW = $clog2(CORDIC_STAGES);
    localparam logic signed [XY_W-1:0] CORDIC_ONE = XY_W'(1) << 28;

    // Slope and march datapath
    localparam int K_W     = QUO_W + 2;        // signed slope
    localparam int K_LO_W  = K_W / 2;          // slope split for the shared multiplier
    localparam int MB_W    = K_LO_W + 1;       // multiplier b operand, signed
    localparam int D_W     = CELL_SHIFT + 2;   // signed y distance to first boundary
    localparam int MP_W    = D_W + MB_W;       // one partial product
    localparam int PROD_W  = D_W + K_W;        // full product
    localparam int RX_W    = K_W + 4;          // x march, signed
    localparam int RY_W    = 22;               // y march, signed; never leaves 24-bit range

    localparam longint OUT_MAX = 64'sd8388607;

    typedef struct packed {
        logic [ANGLE_W-1:0] ray_angle;
        logic [POS_W-1:0]   player_x;
        logic [POS_W-1:0]   player_y;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] end_x;
        logic signed [OUT_W-1:0] end_y;
        logic                    hit_wall;
        logic [STEP_W-1:0]       step_count;
    } result_t;

    // Handshake between the top level and the cotangent unit
    typedef struct packed {
        logic           valid;
        logic [U_W-1:0] angle;  // 1..16384, 16384 = quarter turn
    } cot_req_t;

    typedef struct packed {
        logic             done;
        logic             neg;  // cosine term came out negative
        logic [QUO_W-1:0] quo;  // |cot| in Q.16
    } cot_rsp_t;

    // Arctangent of 2^-i in 2^24-per-turn units
    function automatic logic [Z_W-1:0] atan_unit(input logic [ATAN_IW-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = Z_W'(2097152);
            5'd1:    v = Z_W'(1238021);
            5'd2:    v = Z_W'(654136);
            5'd3:    v = Z_W'(332050);
            5'd4:    v = Z_W'(166669);
            5'd5:    v = Z_W'(83416);
            5'd6:    v = Z_W'(41718);
            5'd7:    v = Z_W'(20860);
            5'd8:    v = Z_W'(10430);
            5'd9:    v = Z_W'(5215);
            5'd10:   v = Z_W'(2608);
            5'd11:   v = Z_W'(1304);
            5'd12:   v = Z_W'(652);
            5'd13:   v = Z_W'(326);
            5'd14:   v = Z_W'(163);
            5'd15:   v = Z_W'(81);
            5'd16:   v = Z_W'(41);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/grid_ray_horizontal_hit_unit.sv
// Horizontal grid ray hit unit: marches a ray across tile rows of an 8x8 wall map.
// A horizontal ray is answered in the cycle after start; other rays go through grhh_cot
// (17 CORDIC steps and 46 one-bit divide steps, both skipped at an exact quarter turn),
// then the multiply and placement states, then step up to DEPTH tile rows.
// Throughput: one ray at a time, busy until the done strobe; results cannot be held off.
// Reset: asynchronous, active low; clears the sequencer and the wall map to all floor.

module grid_ray_horizontal_hit_unit (
    input  logic             clk,
    input  logic             rst_n,
    // command beat
    input  logic             start,
    output logic             busy,
    input  grhh_pkg::cmd_t   cmd,
    // wall map write
    input  logic             wall_cfg_valid,
    output logic             wall_cfg_ready,
    input  logic [grhh_pkg::MAP_BITS-1:0] wall_cfg_data,
    // result beat, one cycle, cannot be held off
    output logic             done,
    output grhh_pkg::result_t result
);

    // Sequencer:
    //   S_IDLE     take a command; horizontal rays answer at once
    //   S_WAIT_COT wait for |cot|, form the signed x slope k
    //   S_MUL_LO   d * low half of k on the shared multiplier
    //   S_MUL_HI   d * high half of k, keep the low product
    //   S_MUL_SUM  combine the halves
    //   S_PLACE    first boundary point and x step
    //   S_STEP     one tile row per cycle until wall or depth
    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_COT,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_PLACE,
        S_STEP
    } state_t;

    localparam logic signed [grhh_pkg::RX_W-1:0] RX_HI = grhh_pkg::RX_W'(grhh_pkg::OUT_MAX);
    localparam logic signed [grhh_pkg::RX_W-1:0] RX_LO =
        -grhh_pkg::RX_W'(grhh_pkg::OUT_MAX) - grhh_pkg::RX_W'(1);
    localparam logic [grhh_pkg::RY_W-1:0] TILE_Y = grhh_pkg::RY_W'(1) << grhh_pkg::CELL_SHIFT;
    localparam logic [grhh_pkg::D_W-1:0]  TILE_D = grhh_pkg::D_W'(1) << grhh_pkg::CELL_SHIFT;

    state_t state_reg;
    logic [grhh_pkg::MAP_BITS-1:0]        wall_map_reg;
    grhh_pkg::cot_req_t                   cot_req_reg;
    grhh_pkg::cot_rsp_t                   cot_rsp;
    logic                                 done_reg;
    grhh_pkg::result_t                    result_reg;

    logic                                 up_reg;     // ray looks toward smaller y
    logic                                 fold_reg;   // angle folded past a quarter turn
    logic [grhh_pkg::POS_W-1:0]           px_reg;
    logic signed [grhh_pkg::D_W-1:0]      d_reg;      // player_y minus first boundary y
    logic signed [grhh_pkg::K_W-1:0]      k_reg;
    logic signed [grhh_pkg::MP_W-1:0]     prod_reg;
    logic signed [grhh_pkg::PROD_W-1:0]   acc_reg;
    logic signed [grhh_pkg::RX_W-1:0]     rx_reg;
    logic signed [grhh_pkg::RX_W-1:0]     xo_reg;
    logic signed [grhh_pkg::RY_W-1:0]     ry_reg;
    logic [grhh_pkg::STEP_W-1:0]          steps_reg;

    // command decode
    logic [grhh_pkg::U_W-1:0]   t_ang, u_ang;
    logic                       fold;
    logic                       horizontal;
    logic [grhh_pkg::RY_W-1:0]  base_y;
    logic [grhh_pkg::D_W-1:0]   py_low;

    // shared multiplier
    logic signed [grhh_pkg::MB_W-1:0] mul_b;
    logic signed [grhh_pkg::MP_W-1:0] mul_p;
    logic signed [grhh_pkg::PROD_W-1:0] prod_ext;

    // placement
    logic signed [grhh_pkg::RX_W-1:0] k_ext;
    logic signed [grhh_pkg::RX_W-1:0] rx_next;
    logic signed [grhh_pkg::RX_W-1:0] xo_next;

    // cell lookup
    logic                          col_ok, row_ok, wall;
    logic [grhh_pkg::MAP_IDX_W-1:0] cell_idx;

    function automatic logic signed [grhh_pkg::OUT_W-1:0] sat_x(
        input logic signed [grhh_pkg::RX_W-1:0] v
    );
        logic signed [grhh_pkg::RX_W-1:0] c;
        c = v;
        if (v > RX_HI)
            c = RX_HI;
        else if (v < RX_LO)
            c = RX_LO;
        return c[grhh_pkg::OUT_W-1:0];
    endfunction

    always_comb
    begin
        t_ang      = cmd.ray_angle[grhh_pkg::U_W-1:0];
        fold       = (t_ang > grhh_pkg::QUARTER);
        u_ang      = fold ? (grhh_pkg::U_W'(32768 - 0) - t_ang) : t_ang;
        horizontal = (cmd.ray_angle == '0) || (cmd.ray_angle == grhh_pkg::HALF_TURN);
        base_y     = grhh_pkg::RY_W'({cmd.player_y[grhh_pkg::POS_W-1:grhh_pkg::CELL_SHIFT],
                                      grhh_pkg::CELL_SHIFT'(0)});
        py_low     = grhh_pkg::D_W'(cmd.player_y[grhh_pkg::CELL_SHIFT-1:0]);
    end

    // low half unsigned, high half signed
    always_comb
    begin
        if (state_reg == S_MUL_LO)
            mul_b = $signed({1'b0, k_reg[grhh_pkg::K_LO_W-1:0]});
        else
            mul_b = $signed({k_reg[grhh_pkg::K_W-1], k_reg[grhh_pkg::K_W-1:grhh_pkg::K_LO_W]});
        mul_p    = d_reg * mul_b;
        prod_ext = grhh_pkg::PROD_W'(prod_reg);
    end

    always_comb
    begin
        k_ext   = grhh_pkg::RX_W'(k_reg);
        rx_next = grhh_pkg::RX_W'(acc_reg >>> grhh_pkg::COT_FRAC)
                  + $signed(grhh_pkg::RX_W'(px_reg));
        // x step is -(y step) * k in Q.16
        xo_next = up_reg ? (k_ext >>> grhh_pkg::XO_SHIFT) : ((-k_ext) >>> grhh_pkg::XO_SHIFT);
    end

    // off-map cells read as floor
    always_comb
    begin
        col_ok   = !rx_reg[grhh_pkg::RX_W-1]
                   && (rx_reg[grhh_pkg::RX_W-1:grhh_pkg::CELL_SHIFT]
                       < (grhh_pkg::RX_W - grhh_pkg::CELL_SHIFT)'(grhh_pkg::MAP_WIDTH));
        row_ok   = !ry_reg[grhh_pkg::RY_W-1]
                   && (ry_reg[grhh_pkg::RY_W-1:grhh_pkg::CELL_SHIFT]
                       < (grhh_pkg::RY_W - grhh_pkg::CELL_SHIFT)'(grhh_pkg::MAP_HEIGHT));
        cell_idx = grhh_pkg::MAP_IDX_W'(ry_reg[grhh_pkg::CELL_SHIFT +: grhh_pkg::ROW_W]
                                        * grhh_pkg::MAP_WIDTH)
                   + grhh_pkg::MAP_IDX_W'(rx_reg[grhh_pkg::CELL_SHIFT +: grhh_pkg::COL_W]);
        wall     = col_ok && row_ok && wall_map_reg[cell_idx];
    end

    grhh_cot u_cot (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cot_req_reg),
        .rsp   (cot_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wall_map_reg <= '0;
            cot_req_reg  <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            up_reg       <= 1'b0;
            fold_reg     <= 1'b0;
            px_reg       <= '0;
            d_reg        <= '0;
            k_reg        <= '0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            rx_reg       <= '0;
            xo_reg       <= '0;
            ry_reg       <= '0;
            steps_reg    <= '0;
        end
        else
        begin
            done_reg          <= 1'b0;
            cot_req_reg.valid <= 1'b0;

            if (wall_cfg_valid && wall_cfg_ready)
                wall_map_reg <= wall_cfg_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (horizontal)
                        begin
                            // flat ray never crosses a row boundary
                            result_reg.end_x      <= $signed(grhh_pkg::OUT_W'(cmd.player_x));
                            result_reg.end_y      <= $signed(grhh_pkg::OUT_W'(cmd.player_y));
                            result_reg.hit_wall   <= 1'b0;
                            result_reg.step_count <= '0;
                            done_reg              <= 1'b1;
                        end
                        else
                        begin
                            up_reg            <= cmd.ray_angle[grhh_pkg::ANGLE_W-1];
                            fold_reg          <= fold;
                            px_reg            <= cmd.player_x;
                            cot_req_reg.valid <= 1'b1;
                            cot_req_reg.angle <= u_ang;
                            if (cmd.ray_angle[grhh_pkg::ANGLE_W-1])
                            begin
                                // looking up: one LSB above the current row
                                ry_reg <= $signed(base_y - grhh_pkg::RY_W'(1));
                                d_reg  <= $signed(py_low + grhh_pkg::D_W'(1));
                            end
                            else
                            begin
                                ry_reg <= $signed(base_y + TILE_Y);
                                d_reg  <= $signed(py_low - TILE_D);
                            end
                            state_reg <= S_WAIT_COT;
                        end
                    end
                end
                S_WAIT_COT:
                begin
                    if (cot_rsp.done)
                    begin
                        if (cot_rsp.neg ^ fold_reg)
                            k_reg <= $signed(grhh_pkg::K_W'(cot_rsp.quo));
                        else
                            k_reg <= -$signed(grhh_pkg::K_W'(cot_rsp.quo));
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    acc_reg   <= prod_ext;
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_SUM;
                end
                S_MUL_SUM:
                begin
                    acc_reg   <= acc_reg + (prod_ext <<< grhh_pkg::K_LO_W);
                    state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    rx_reg    <= rx_next;
                    xo_reg    <= xo_next;
                    steps_reg <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if ((steps_reg == grhh_pkg::STEP_W'(grhh_pkg::DEPTH)) || wall)
                    begin
                        result_reg.end_x      <= sat_x(rx_reg);
                        result_reg.end_y      <= grhh_pkg::OUT_W'(ry_reg);
                        result_reg.hit_wall   <= wall
                                                 && (steps_reg != grhh_pkg::STEP_W'(grhh_pkg::DEPTH));
                        result_reg.step_count <= steps_reg;
                        done_reg              <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                    else
                    begin
                        rx_reg    <= rx_reg + xo_reg;
                        ry_reg    <= up_reg ? (ry_reg - $signed(TILE_Y))
                                            : (ry_reg + $signed(TILE_Y));
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign wall_cfg_ready = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign result         = result_reg;

endmodule

FILE: hdl/grhh_cot.sv
// Cotangent unit: 17-step CORDIC rotation, then a restoring divide, one bit a cycle.
// Depends on grhh_pkg.

module grhh_cot (
    input  logic              clk,
    input  logic              rst_n,
    input  grhh_pkg::cot_req_t req,
    output grhh_pkg::cot_rsp_t rsp
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROT,
        C_PREP,
        C_DIV
    } state_t;

    state_t state_reg;
    logic [grhh_pkg::CNT_W-1:0]          cnt_reg;
    logic signed [grhh_pkg::XY_W-1:0]    x_reg;
    logic signed [grhh_pkg::XY_W-1:0]    y_reg;
    logic signed [grhh_pkg::Z_W-1:0]     z_reg;
    logic [grhh_pkg::DVS_W-1:0]          rem_reg;
    logic [grhh_pkg::DVS_W-1:0]          dvs_reg;
    logic [grhh_pkg::QUO_W-1:0]          quo_reg;
    logic                                neg_reg;
    logic                                done_reg;

    // one rotation step
    logic signed [grhh_pkg::XY_W-1:0] dx, dy;
    logic signed [grhh_pkg::Z_W-1:0]  dz;
    // one divide step
    logic [grhh_pkg::DVS_W:0]   shifted;
    logic [grhh_pkg::DVS_W+1:0] diff;
    logic [grhh_pkg::XY_W-1:0]  xabs;

    always_comb
    begin
        dx      = y_reg >>> cnt_reg;
        dy      = x_reg >>> cnt_reg;
        dz      = $signed(grhh_pkg::atan_unit(cnt_reg[grhh_pkg::ATAN_IW-1:0]));
        shifted = {rem_reg, quo_reg[grhh_pkg::QUO_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        xabs    = x_reg[grhh_pkg::XY_W-1] ? (-x_reg) : x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.angle == grhh_pkg::QUARTER)
                        begin
                            // exact quarter turn: cotangent is zero
                            quo_reg  <= '0;
                            neg_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            x_reg     <= grhh_pkg::CORDIC_ONE;
                            y_reg     <= '0;
                            z_reg     <= $signed(grhh_pkg::Z_W'({req.angle, 8'b0}));
                            cnt_reg   <= '0;
                            state_reg <= C_ROT;
                        end
                    end
                end
                C_ROT:
                begin
                    if (!z_reg[grhh_pkg::Z_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - dz;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + dz;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == grhh_pkg::CNT_W'(grhh_pkg::CORDIC_STAGES - 1))
                        state_reg <= C_PREP;
                end
                C_PREP:
                begin
                    neg_reg <= x_reg[grhh_pkg::XY_W-1];
                    quo_reg <= {xabs[grhh_pkg::XMAG_W-1:0], grhh_pkg::COT_FRAC'(0)};
                    // sine not positive: divide by one
                    if (y_reg[grhh_pkg::XY_W-1] || (y_reg == '0))
                        dvs_reg <= grhh_pkg::DVS_W'(1);
                    else
                        dvs_reg <= y_reg[grhh_pkg::DVS_W-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    if (!diff[grhh_pkg::DVS_W+1])
                    begin
                        rem_reg <= diff[grhh_pkg::DVS_W-1:0];
                        quo_reg <= {quo_reg[grhh_pkg::QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted[grhh_pkg::DVS_W-1:0];
                        quo_reg <= {quo_reg[grhh_pkg::QUO_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == grhh_pkg::CNT_W'(grhh_pkg::QUO_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.neg  = neg_reg;
    assign rsp.quo  = quo_reg;

endmodule
